>>> sv/x86sub_pkg.sv
// Shared types and encoding constants for the 64-bit SUB instruction encoder.
// No dependencies; used by the encoder, serializer and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package x86sub_pkg;

   // Longest instruction: REX, opcode, ModRM, SIB, disp32, imm32
   localparam int MAX_BYTES = 12;
   localparam int CODE_W    = MAX_BYTES * 8;
   localparam int LEN_W     = $clog2(MAX_BYTES + 1);

   // Operand forms
   typedef enum logic [2:0] {
      CMD_REG_REG = 3'd0,
      CMD_REG_MEM = 3'd1,
      CMD_MEM_REG = 3'd2,
      CMD_REG_IMM = 3'd3,
      CMD_MEM_IMM = 3'd4
   } cmd_type;

   // Encoding bytes and fields
   localparam logic [7:0] REX_W        = 8'h48;
   localparam logic [7:0] OP_SUB_MR    = 8'h29;
   localparam logic [7:0] OP_SUB_RM    = 8'h2B;
   localparam logic [7:0] OP_GRP1_IB   = 8'h83;
   localparam logic [7:0] OP_GRP1_ID   = 8'h81;
   localparam logic [7:0] MODRM_REG    = 8'hC0;
   localparam logic [7:0] SIB_NO_INDEX = 8'h20;
   localparam logic [2:0] EXT_SUB      = 3'd5;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] RM_RIP       = 3'd5;

   localparam logic [1:0] MOD_NO_DISP  = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;

   // One request as held in the input register
   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  dest_reg;
      logic [3:0]  source_reg;
      logic [3:0]  base_reg;
      logic [31:0] displacement;
      logic [31:0] immediate;
   } req_type;

   // Encoded instruction: bytes in memory order from the low end
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } enc_type;

   // True when a 32-bit two's complement value lies in -128..127
   function automatic logic fits8(input logic [31:0] v);
      return (v[31:7] == '0) || (v[31:7] == '1);
   endfunction

endpackage

`default_nettype wire

>>> sv/x86sub_encoder.sv
// Combinational encoder: turns one registered request into up to twelve
// instruction bytes and a byte count. Depends on x86sub_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86sub_encoder (
   input  x86sub_pkg::req_type req_i,
   output x86sub_pkg::enc_type enc_o
);
   import x86sub_pkg::*;

   logic [2:0]        lo_base;
   logic              disp_zero;
   logic              disp_small;
   logic              imm_small;
   logic [1:0]        mem_mod;
   logic [2:0]        mem_n;
   logic [2:0]        reg_field;
   logic [7:0]        rex_v;
   logic [7:0]        op_v;
   logic [7:0]        modrm_v;
   logic [31:0]       disp_v;
   logic [31:0]       imm_v;
   logic              use_mem;
   logic              use_imm;
   logic              valid_cmd;
   logic [CODE_W-1:0] code_v;
   logic [LEN_W-1:0]  pos_v;

   // Classify displacement and immediate sizes
   assign lo_base    = req_i.base_reg[2:0];
   assign disp_zero  = (req_i.displacement == '0);
   assign disp_small = fits8(req_i.displacement);
   assign imm_small  = fits8(req_i.immediate);

   // Pick mod; a zero displacement on an rm of 5 needs an explicit disp8
   always_comb begin
      if (disp_zero && (lo_base != RM_RIP)) begin
         mem_mod = MOD_NO_DISP;
         mem_n   = 3'd0;
      end else if (disp_small) begin
         mem_mod = MOD_DISP8;
         mem_n   = 3'd1;
      end else begin
         mem_mod = MOD_DISP32;
         mem_n   = 3'd4;
      end
   end

   // Prefix, opcode and ModRM per form
   always_comb begin
      rex_v     = REX_W;
      op_v      = OP_SUB_MR;
      reg_field = req_i.source_reg[2:0];
      modrm_v   = '0;
      use_mem   = 1'b0;
      use_imm   = 1'b0;
      valid_cmd = 1'b1;
      unique case (req_i.cmd)
         CMD_REG_REG: begin
            rex_v   = REX_W | {5'd0, req_i.source_reg[3], 1'b0, req_i.dest_reg[3]};
            op_v    = OP_SUB_MR;
            modrm_v = MODRM_REG | {2'd0, req_i.source_reg[2:0], req_i.dest_reg[2:0]};
         end
         CMD_REG_MEM: begin
            rex_v     = REX_W | {5'd0, req_i.dest_reg[3], 1'b0, req_i.base_reg[3]};
            op_v      = OP_SUB_RM;
            reg_field = req_i.dest_reg[2:0];
            use_mem   = 1'b1;
         end
         CMD_MEM_REG: begin
            rex_v     = REX_W | {5'd0, req_i.source_reg[3], 1'b0, req_i.base_reg[3]};
            op_v      = OP_SUB_MR;
            reg_field = req_i.source_reg[2:0];
            use_mem   = 1'b1;
         end
         CMD_REG_IMM: begin
            rex_v   = REX_W | {7'd0, req_i.dest_reg[3]};
            op_v    = imm_small ? OP_GRP1_IB : OP_GRP1_ID;
            modrm_v = MODRM_REG | {2'd0, EXT_SUB, req_i.dest_reg[2:0]};
            use_imm = 1'b1;
         end
         CMD_MEM_IMM: begin
            rex_v     = REX_W | {7'd0, req_i.base_reg[3]};
            op_v      = imm_small ? OP_GRP1_IB : OP_GRP1_ID;
            reg_field = EXT_SUB;
            use_mem   = 1'b1;
            use_imm   = 1'b1;
         end
         default: begin
            valid_cmd = 1'b0;
         end
      endcase
      if (use_mem) begin
         modrm_v = {mem_mod, reg_field, lo_base};
      end
   end

   // Trim displacement and immediate to the bytes that are sent
   assign disp_v = (mem_n == 3'd1) ? {24'd0, req_i.displacement[7:0]}
                                   : req_i.displacement;
   assign imm_v  = imm_small ? {24'd0, req_i.immediate[7:0]} : req_i.immediate;

   // Append optional SIB, displacement and immediate after the fixed head
   always_comb begin
      code_v = {{(CODE_W-24){1'b0}}, modrm_v, op_v, rex_v};
      pos_v  = LEN_W'(3);
      if (use_mem) begin
         if (lo_base == RM_SIB) begin
            code_v = code_v | ({{(CODE_W-8){1'b0}}, SIB_NO_INDEX | {5'd0, lo_base}}
                               << {pos_v, 3'b000});
            pos_v  = pos_v + LEN_W'(1);
         end
         if (mem_n != 3'd0) begin
            code_v = code_v | ({{(CODE_W-32){1'b0}}, disp_v} << {pos_v, 3'b000});
            pos_v  = pos_v + LEN_W'(mem_n);
         end
      end
      if (use_imm) begin
         code_v = code_v | ({{(CODE_W-32){1'b0}}, imm_v} << {pos_v, 3'b000});
         pos_v  = pos_v + (imm_small ? LEN_W'(1) : LEN_W'(4));
      end
   end

   // Unused form codes produce no bytes
   assign enc_o.code = code_v;
   assign enc_o.len  = valid_cmd ? pos_v : '0;

endmodule

`default_nettype wire

>>> sv/x86sub_serializer.sv
// Result register and byte serializer: holds one encoded instruction, sends it
// one byte per cycle while rsp_tready is high, marks the last. Uses x86sub_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86sub_serializer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load_valid,
   input  x86sub_pkg::enc_type  enc_i,
   output logic                 load_ready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import x86sub_pkg::*;

   logic [CODE_W-1:0] code_ff, code_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              valid_ff, valid_in;
   logic              send;
   logic              last;
   logic              load;

   assign last       = (left_ff == LEN_W'(1));
   assign send       = valid_ff && rsp_tready;
   assign load_ready = !valid_ff || (send && last);
   assign load       = load_valid && load_ready;

   // Load a new instruction, shift out a byte, or hold
   always_comb begin
      code_in  = code_ff;
      left_in  = left_ff;
      valid_in = valid_ff;
      if (load) begin
         code_in  = enc_i.code;
         left_in  = enc_i.len;
         valid_in = (enc_i.len != '0);
      end else if (send) begin
         code_in  = code_ff >> 8;
         left_in  = left_ff - LEN_W'(1);
         valid_in = !last;
      end else if (load_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
      code_ff <= code_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = code_ff[7:0];
   assign rsp_tlast  = last;

   // A valid byte always has between one and twelve bytes left
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (left_ff != '0) && (left_ff <= LEN_W'(MAX_BYTES)))
      else $error("serializer: byte count out of range");

   // An instruction is never cut short after a non-final byte
   assert property (@(posedge clock) disable iff (reset)
      (send && !last) |=> valid_ff && (left_ff == $past(left_ff) - LEN_W'(1)))
      else $error("serializer: instruction truncated");

   // A stalled byte keeps its count
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> valid_ff && $stable(left_ff))
      else $error("serializer: stalled count changed");

endmodule

`default_nettype wire

>>> sv/x86_64_sub_instruction_encoder.sv
// Top level of the 64-bit SUB instruction encoder: input register, encoder
// and byte serializer. Depends on x86sub_pkg, x86sub_encoder, x86sub_serializer.
//
// Each request encodes one 64-bit SUB in one of five operand forms (tuser
// selects it) and returns its bytes in memory order, one per response beat,
// with tlast on the final byte. An instruction is 3 to 12 bytes long and
// holds the response channel until its last byte is sent; the output port
// sets the throughput, one byte per cycle while rsp_tready is high. A
// request passes the input and result registers before its first byte. A
// request with an unused form code is consumed and produces no response.
// The next request is taken while the previous one is still being sent,
// and is encoded straight into the result register as its last byte leaves.
`timescale 1ns / 1ps
`default_nettype none

module x86_64_sub_instruction_encoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [2:0]  req_tuser,  // cmd
   input  wire  [79:0] req_tdata,  // dest_reg[3:0], source_reg[7:4], base_reg[11:8],
                                   // displacement[43:12], immediate[75:44], zero fill
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,  // code_byte
   output logic        rsp_tlast   // last_byte
);
   import x86sub_pkg::*;

   req_type req_ff, req_in;
   logic    in_valid_ff, in_valid_in;
   logic    ser_ready;
   enc_type enc;

   // Hold one request ahead of the encoder
   assign req_tready = !in_valid_ff || ser_ready;

   always_comb begin
      req_in      = req_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         req_in.cmd          = req_tuser;
         req_in.dest_reg     = req_tdata[3:0];
         req_in.source_reg   = req_tdata[7:4];
         req_in.base_reg     = req_tdata[11:8];
         req_in.displacement = req_tdata[43:12];
         req_in.immediate    = req_tdata[75:44];
         in_valid_in         = 1'b1;
      end else if (ser_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      req_ff <= req_in;
   end

   x86sub_encoder u_encoder (
      .req_i (req_ff),
      .enc_o (enc)
   );

   x86sub_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .enc_i      (enc),
      .load_ready (ser_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
